// ===== rtl/mvt_pkg.sv =====
`default_nettype none

package mvt_pkg;

  // Fixed geometry of the stored matrix and the word format.
  localparam int SIDE    = 4;
  localparam int WORD_W  = 32;
  localparam int ENTRIES = SIDE * SIDE;
  localparam int IDX_W   = $clog2(ENTRIES);

  // Defaults for the top-level parameters.
  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Command queue between the front and the back (depth is a power of two).
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Result queue at the output (depth is a power of two).
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Widths inside the dot-product datapath.
  localparam int PROD_W = 2 * WORD_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_XFORM = 1'b1
  } action_e;

  // A classified command: for a load, data[0] carries the entry value.
  typedef struct packed {
    action_e               action;
    logic [IDX_W-1:0]      index;
    word_t [SIDE-1:0]      data;
  } cmd_t;

  typedef struct packed {
    word_t [SIDE-1:0] comp;
    logic             overflowed;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mvt_front.sv =====
`default_nettype none

module mvt_front
  import mvt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              action_i,
  input  wire logic [IDX_W-1:0]  entry_index_i,
  input  wire word_t             entry_value_i,
  input  wire word_t             vec_x_i,
  input  wire word_t             vec_y_i,
  input  wire word_t             vec_z_i,
  input  wire word_t             vec_w_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_take_i
);

  cmd_t                 in_cmd;
  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 push_ok;
  logic                 take_ok;

  // Classify the incoming transaction and pack the entry index and the data fields it uses.
  always_comb begin
    in_cmd        = '0;
    in_cmd.action = action_e'(action_i);
    in_cmd.index  = entry_index_i;
    if (in_cmd.action == ACT_LOAD) begin
      in_cmd.data[0] = entry_value_i;
    end else begin
      in_cmd.data[0] = vec_x_i;
      in_cmd.data[1] = vec_y_i;
      in_cmd.data[2] = vec_z_i;
      in_cmd.data[3] = vec_w_i;
    end
  end

  assign full        = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push_ok     = push && !full;
  assign take_ok     = cmd_take_i && cmd_valid_o;

  // Pointer and fill-level bookkeeping; pointers wrap at the power-of-two depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (take_ok) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_ok && !take_ok) begin
      count_d = count_q + 1'b1;
    end else if (!push_ok && take_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mvt_back.sv =====
`default_nettype none

module mvt_back
  import mvt_pkg::*;
#(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire cmd_t                 cmd_i,
  output logic                      cmd_take_o,
  input  wire logic [OUT_CNT_W-1:0] out_level_i,
  output logic                      res_valid_o,
  output result_t                   res_o
);

  localparam int SPACE_W = OUT_CNT_W + 1;

  word_t   matrix_q [ENTRIES];
  prod_t   prod_q   [SIDE][SIDE];
  prod_t   prod_d   [SIDE][SIDE];
  pair_t   pair_q   [SIDE][2];
  pair_t   pair_d   [SIDE][2];
  logic    prod_valid_q;
  logic    pair_valid_q;
  logic    issue_ok;
  logic    xform_go;
  logic    load_go;
  logic [SPACE_W-1:0] used;

  // Results already queued plus those still in the pipeline must fit the output queue.
  assign used = SPACE_W'(out_level_i) + SPACE_W'(prod_valid_q) + SPACE_W'(pair_valid_q);
  assign issue_ok = (used < SPACE_W'(OUT_DEPTH));

  assign cmd_take_o = cmd_valid_i && ((cmd_i.action == ACT_LOAD) || issue_ok);
  assign load_go    = cmd_take_o && (cmd_i.action == ACT_LOAD);
  assign xform_go   = cmd_take_o && (cmd_i.action == ACT_XFORM);

  // Matrix store, reset to identity; loads apply in command order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if ((e / SIDE) == (e % SIDE)) begin
          matrix_q[e] <= word_t'(1) << FRAC_BITS;
        end else begin
          matrix_q[e] <= '0;
        end
      end
    end else if (load_go) begin
      matrix_q[cmd_i.index] <= cmd_i.data[0];
    end
  end

  // Stage one: every matrix entry times its vector component, unused columns zeroed.
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (c < DIM) begin
          prod_d[r][c] = matrix_q[r * SIDE + c] * cmd_i.data[c];
        end else begin
          prod_d[r][c] = '0;
        end
      end
    end
  end

  // Stage two: pairwise sums of the products of each row.
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      pair_d[r][0] = PAIR_W'(prod_q[r][0]) + PAIR_W'(prod_q[r][1]);
      pair_d[r][1] = PAIR_W'(prod_q[r][2]) + PAIR_W'(prod_q[r][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      pair_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= xform_go;
      pair_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xform_go) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q) begin
      pair_q <= pair_d;
    end
  end

  // Final stage: row total, floor shift, saturation and the overflow flag.
  always_comb begin
    sum_t total;
    sum_t shifted;
    logic fits;
    res_o = '0;
    for (int r = 0; r < SIDE; r++) begin
      total   = SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]);
      shifted = total >>> FRAC_BITS;
      fits    = (&shifted[SUM_W-1:WORD_W-1]) || !(|shifted[SUM_W-1:WORD_W-1]);
      if (r < DIM) begin
        if (fits) begin
          res_o.comp[r] = shifted[WORD_W-1:0];
        end else begin
          res_o.comp[r]  = shifted[SUM_W-1] ? WORD_MIN : WORD_MAX;
          res_o.overflowed = 1'b1;
        end
      end
    end
  end

  assign res_valid_o = pair_valid_q;

endmodule

`default_nettype wire

// ===== rtl/mvt_out_fifo.sv =====
`default_nettype none

module mvt_out_fifo
  import mvt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_valid_i,
  input  wire result_t              wr_data_i,
  input  wire logic                 pop,
  output logic                      empty,
  output result_t                   rd_data_o,
  output logic [OUT_CNT_W-1:0]      level_o
);

  result_t              mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic                 pop_ok;

  assign empty     = (count_q == '0);
  assign pop_ok    = pop && !empty;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign level_o   = count_q;

  // The producer only writes when space was reserved, so no full check is needed here.
  always_comb begin
    count_d = count_q;
    if (wr_valid_i && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (!wr_valid_i && pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix_vector_transform_4x4.sv =====
// Matrix-vector transform engine in signed Q16.16 fixed point.
// Input channel (push/full): a transaction is taken on a rising edge with push high
// and full low. action_i low loads entry_index_i (row*4+column) of the stored matrix
// with entry_value_i and produces no result; action_i high transforms the vector
// vec_x_i..vec_w_i and produces exactly one result.
// Result channel (empty/pop): while empty is low the oldest result is on out_x_o..out_w_o
// and overflowed_o; it is consumed on a rising edge with pop high.
// Pipeline: a transform passes the command queue, then the product and pair registers;
// empty falls when its result is queued, and loads and transforms keep their order.
// Throughput: one transaction per cycle while full stays low, set by the fully parallel
// multiplier array (sixteen products per cycle) behind a two-entry command queue.
// Stalls: results wait in a four-entry queue; when it and the pipeline hold four results,
// transforms stop issuing, the command queue fills and full rises. A load that reaches
// the head of the command queue still completes, but anything behind a held transform waits.
// Reset: the matrix returns to identity, both queues empty, full low, empty high.
`default_nettype none

module matrix_vector_transform_4x4
  import mvt_pkg::*;
#(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              action_i,
  input  wire logic [IDX_W-1:0]  entry_index_i,
  input  wire word_t             entry_value_i,
  input  wire word_t             vec_x_i,
  input  wire word_t             vec_y_i,
  input  wire word_t             vec_z_i,
  input  wire word_t             vec_w_i,
  output logic                   empty,
  input  wire logic              pop,
  output word_t                  out_x_o,
  output word_t                  out_y_o,
  output word_t                  out_z_o,
  output word_t                  out_w_o,
  output logic                   overflowed_o
);

  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_take;
  logic                 res_valid;
  result_t              res;
  result_t              head;
  logic [OUT_CNT_W-1:0] out_level;

  // Front: accepts and classifies transactions into the command queue.
  mvt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .vec_w_i       (vec_w_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  // Back: matrix store and the pipelined dot-product datapath.
  mvt_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_level_i (out_level),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result queue towards the consumer.
  mvt_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_data_i  (res),
    .pop        (pop),
    .empty      (empty),
    .rd_data_o  (head),
    .level_o    (out_level)
  );

  assign out_x_o      = head.comp[0];
  assign out_y_o      = head.comp[1];
  assign out_z_o      = head.comp[2];
  assign out_w_o      = head.comp[3];
  assign overflowed_o = head.overflowed;

endmodule

`default_nettype wire

// ===== rtl/mvt_checker.sv =====
`default_nettype none

module mvt_checker
  import mvt_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  push,
  input wire logic  full,
  input wire logic  action_i,
  input wire logic  empty,
  input wire logic  pop,
  input wire word_t out_x_o,
  input wire word_t out_y_o,
  input wire word_t out_z_o,
  input wire word_t out_w_o,
  input wire logic  overflowed_o
);

  logic [7:0] pending_q;
  logic       xform_in;
  logic       res_out;

  assign xform_in = push && !full && (action_e'(action_i) == ACT_XFORM);
  assign res_out  = pop && !empty;

  // Transforms accepted but whose results have not yet been consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (xform_in && !res_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (!xform_in && res_out) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A result is only offered when a transform is owed.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != '0))
    else $error("result offered without an outstanding transform");

  // Back-pressure only arises from outstanding transforms.
  a_full_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == '0) |-> !full)
    else $error("input stalled with no transform outstanding");

  // A flagged result carries at least one saturated component.
  a_flag_means_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflowed_o) |->
      (out_x_o == WORD_MAX || out_x_o == WORD_MIN ||
       out_y_o == WORD_MAX || out_y_o == WORD_MIN ||
       out_z_o == WORD_MAX || out_z_o == WORD_MIN ||
       out_w_o == WORD_MAX || out_w_o == WORD_MIN))
    else $error("overflow flag without a saturated component");

  // A stalled result stays put.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_x_o) && $stable(out_y_o) &&
                          $stable(out_z_o) && $stable(out_w_o) && $stable(overflowed_o)))
    else $error("stalled result changed");

endmodule

bind matrix_vector_transform_4x4 mvt_checker u_checker (.*);

`default_nettype wire

// ===== tb/transform_checker.sv =====
`timescale 1ns / 100ps

module transform_checker
  import mvt_pkg::*;
#(
  parameter int DIM       = DIM_DEFAULT,
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic             full,
  input  logic             action_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  word_t            entry_value_i,
  input  word_t            vec_x_i,
  input  word_t            vec_y_i,
  input  word_t            vec_z_i,
  input  word_t            vec_w_i,
  input  logic             empty,
  input  logic             pop,
  input  word_t            out_x_o,
  input  word_t            out_y_o,
  input  word_t            out_z_o,
  input  word_t            out_w_o,
  input  logic             overflowed_o,
  output int               fail_count,
  output int               awaited_count,
  output int               loads_seen,
  output int               transforms_seen,
  output int               saturated_seen
);

  localparam int REPORT_LIMIT = 10;

  // Private copy of the stored matrix and the results still owed by the block.
  word_t   matrix_copy [ENTRIES];
  result_t awaited_vertices [$];
  int      results_seen;

  // Exact dot products, floored by the arithmetic shift, then clamped to a word.
  function automatic result_t transform_vertex(word_t vx, word_t vy, word_t vz, word_t vw);
    word_t   vec [SIDE];
    result_t res;
    prod_t   prod;
    sum_t    acc;
    sum_t    scaled;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = vw;
    res = '0;
    for (int row = 0; row < DIM; row++) begin
      acc = '0;
      for (int col = 0; col < DIM; col++) begin
        prod = matrix_copy[row * SIDE + col] * vec[col];
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > sum_t'(WORD_MAX)) begin
        res.comp[row]  = WORD_MAX;
        res.overflowed = 1'b1;
      end else if (scaled < sum_t'(WORD_MIN)) begin
        res.comp[row]  = WORD_MIN;
        res.overflowed = 1'b1;
      end else begin
        res.comp[row] = word_t'(scaled);
      end
    end
    return res;
  endfunction

  // Follow both channels: loads update the copy, transforms queue a prediction,
  // and each result transaction is compared with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        matrix_copy[k] = (k / SIDE == k % SIDE) ? word_t'(1 << FRAC_BITS) : '0;
      end
      awaited_vertices.delete();
      fail_count      <= 0;
      awaited_count   <= 0;
      loads_seen      <= 0;
      transforms_seen <= 0;
      saturated_seen  <= 0;
      results_seen    <= 0;
    end else begin
      if (pop && !empty) begin
        got.comp[0]    = out_x_o;
        got.comp[1]    = out_y_o;
        got.comp[2]    = out_z_o;
        got.comp[3]    = out_w_o;
        got.overflowed = overflowed_o;
        if (awaited_vertices.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("[%0t] Result transaction with nothing awaited: x=%h y=%h z=%h w=%h ovf=%b",
                     $realtime, got.comp[0], got.comp[1], got.comp[2], got.comp[3],
                     got.overflowed);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_vertices.pop_front();
          if (got != want) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("[%0t] Result %0d differs: expected x=%h y=%h z=%h w=%h ovf=%b",
                       $realtime, results_seen, want.comp[0], want.comp[1], want.comp[2],
                       want.comp[3], want.overflowed);
              $display("             actual   x=%h y=%h z=%h w=%h ovf=%b",
                       got.comp[0], got.comp[1], got.comp[2], got.comp[3],
                       got.overflowed);
            end
            fail_count <= fail_count + 1;
          end
        end
        results_seen <= results_seen + 1;
      end

      if (push && !full) begin
        if (action_i == ACT_XFORM) begin
          want = transform_vertex(vec_x_i, vec_y_i, vec_z_i, vec_w_i);
          awaited_vertices.push_back(want);
          transforms_seen <= transforms_seen + 1;
          if (want.overflowed) begin
            saturated_seen <= saturated_seen + 1;
          end
        end else begin
          matrix_copy[entry_index_i] = entry_value_i;
          loads_seen <= loads_seen + 1;
        end
      end

      awaited_count <= awaited_vertices.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mvt_pkg::*;

  localparam int DIM          = DIM_DEFAULT;
  localparam int FRAC_BITS    = FRAC_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 1230;
  localparam int IDLE_PCT     = 31;
  localparam int LOAD_PCT     = 30;
  localparam int STEADY_FIRST = 400;
  localparam int STEADY_LAST  = 650;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;

  localparam word_t ONE = word_t'(1 << FRAC_BITS);

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             push          = 1'b0;
  logic             pop           = 1'b0;
  logic             action_i      = ACT_LOAD;
  logic [IDX_W-1:0] entry_index_i = '0;
  word_t            entry_value_i = '0;
  word_t            vec_x_i       = '0;
  word_t            vec_y_i       = '0;
  word_t            vec_z_i       = '0;
  word_t            vec_w_i       = '0;
  logic             steady        = 1'b0;

  logic  full;
  logic  empty;
  word_t out_x_o;
  word_t out_y_o;
  word_t out_z_o;
  word_t out_w_o;
  logic  overflowed_o;

  int fail_count;
  int awaited_count;
  int loads_seen;
  int transforms_seen;
  int saturated_seen;

  matrix_vector_transform_4x4 #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .vec_x_i       (vec_x_i),
    .vec_y_i       (vec_y_i),
    .vec_z_i       (vec_z_i),
    .vec_w_i       (vec_w_i),
    .empty         (empty),
    .pop           (pop),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .out_w_o       (out_w_o),
    .overflowed_o  (overflowed_o)
  );

  transform_checker #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .vec_x_i         (vec_x_i),
    .vec_y_i         (vec_y_i),
    .vec_z_i         (vec_z_i),
    .vec_w_i         (vec_w_i),
    .empty           (empty),
    .pop             (pop),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .out_w_o         (out_w_o),
    .overflowed_o    (overflowed_o),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count),
    .loads_seen      (loads_seen),
    .transforms_seen (transforms_seen),
    .saturated_seen  (saturated_seen)
  );

  // Free-running clock with a 12 ns period.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Value mix: the extremes, zero, plus and minus one, small values that stay
  // clear of saturation, and full-range words.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return ONE;
      4: return -ONE;
      5, 6, 7: return word_t'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one transaction, after a random gap outside the steady stretch, and hold it until it is taken.
  task automatic send_item(input action_e act, input logic [IDX_W-1:0] idx, input word_t val,
                           input word_t x, input word_t y, input word_t z, input word_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    action_i      <= act;
    entry_index_i <= idx;
    entry_value_i <= val;
    vec_x_i       <= x;
    vec_y_i       <= y;
    vec_z_i       <= z;
    vec_w_i       <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // The fields that a transaction does not use carry random content.
  task automatic load_entry(input logic [IDX_W-1:0] idx, input word_t val);
    send_item(ACT_LOAD, idx, val, word_t'($urandom), word_t'($urandom),
              word_t'($urandom), word_t'($urandom));
  endtask

  task automatic transform(input word_t x, input word_t y, input word_t z, input word_t w);
    send_item(ACT_XFORM, IDX_W'($urandom), word_t'($urandom), x, y, z, w);
  endtask

  // Result side: pop at random, except during the steady stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: give up when no transaction moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No transaction for %0d cycles, %0d results still awaited",
             STALL_LIMIT, awaited_count);
    $display("Test completed with failures");
    $finish;
  end

  // Reset, directed transactions, random traffic, then drain and verdict.
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix passes the extremes straight through.
    transform(WORD_MAX, WORD_MIN, '0, word_t'(-1));
    transform(ONE, -ONE, word_t'(1), word_t'(32'h1234_5678));

    // Positive and negative saturation.
    load_entry(IDX_W'(0), WORD_MAX);
    load_entry(IDX_W'(1), WORD_MAX);
    transform(WORD_MAX, WORD_MAX, '0, '0);
    load_entry(IDX_W'(5), WORD_MIN);
    transform('0, WORD_MAX, '0, '0);

    // Truncation of negative sums rounds towards minus infinity.
    load_entry(IDX_W'(10), word_t'(-1));
    transform('0, '0, word_t'(1), word_t'(-1));

    // Most negative times most negative.
    load_entry(IDX_W'(15), WORD_MIN);
    transform('0, '0, word_t'(-1), WORD_MIN);
    load_entry(IDX_W'(3), -ONE);
    transform(word_t'(1), word_t'(1), word_t'(1), word_t'(1));

    // Back to identity, then an off-diagonal entry of one and a half.
    load_entry(IDX_W'(0), ONE);
    load_entry(IDX_W'(1), '0);
    load_entry(IDX_W'(3), '0);
    load_entry(IDX_W'(5), ONE);
    load_entry(IDX_W'(10), ONE);
    load_entry(IDX_W'(15), ONE);
    load_entry(IDX_W'(12), word_t'(32'h0001_8000));
    transform(ONE, ONE, ONE, ONE);
    load_entry(IDX_W'(12), '0);
    transform(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1));

    // Random traffic with a stretch in which neither side idles.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
      if ($urandom_range(99) < LOAD_PCT) begin
        load_entry(IDX_W'($urandom), pick_word());
      end else begin
        transform(pick_word(), pick_word(), pick_word(), pick_word());
      end
    end
    push <= 1'b0;

    // Let the checker count the last accepted transaction before waiting on it.
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d matrix loads and %0d vector transforms, %0d of them saturating.",
             loads_seen, transforms_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d result transactions failed their check", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
